/* hdl/trss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package trss_pkg;

    // Table geometry defaults and relay count.
    localparam int MAX_ROWS_DEF = 256;
    localparam int RELAY_COUNT  = 8;

    // Relays that exist; pins from index RELAY_COUNT up always read as zero.
    localparam logic [7:0] RELAY_MASK = 8'((64'd1 << RELAY_COUNT) - 64'd1);

    // Field widths.
    localparam int WAIT_W  = 16;
    localparam int RELAY_W = 8;
    localparam int ROW_W   = 9;
    localparam int TPS_W   = 20;
    localparam int BLINK_W = 16;
    localparam int PRESS_W = 16;
    localparam int CFG_W   = 20;
    localparam int CNT_W   = 13;

    // Input actions.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_BUTTON  = 2'd1;
    localparam logic [1:0] ACT_LOAD    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROW_COUNT  = 2'd0;
    localparam logic [1:0] CFG_TICKS_SEC  = 2'd1;
    localparam logic [1:0] CFG_BLINK_HALF = 2'd2;
    localparam logic [1:0] CFG_LONG_PRESS = 2'd3;

    // Configuration reset values.
    localparam logic [ROW_W-1:0]   ROW_COUNT_RST  = 9'd1;
    localparam logic [TPS_W-1:0]   TICKS_SEC_RST  = 20'd1000;
    localparam logic [BLINK_W-1:0] BLINK_HALF_RST = 16'd500;
    localparam logic [PRESS_W-1:0] LONG_PRESS_RST = 16'd1500;

    // Result item as held in the output register.
    typedef struct packed {
        logic [7:0]       relay_pins;
        logic             led;
        logic             running;
        logic             paused;
        logic [ROW_W-1:0] row_now;
        logic             finished;
    } result_t;

endpackage

`default_nettype wire

/* hdl/timed_relay_show_sequencer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Timed relay show sequencer.
// Input channel (in_valid/in_ready) carries one item per transfer: a tick, a
// button release with its press length, or a script row to load into the table.
// Output channel (out_valid/out_ready) returns exactly one status item per input
// item: relay pins (active low), LED, running, paused, current row, finished.
// Configuration is a plain write port (cfg_wr_en, cfg_addr, cfg_wdata) that
// takes effect at the clock edge of the write.
// For each item, in the transfer cycle the script table is read at the
// current row; in the update step (S_EXEC) the state is updated from the read
// data and the result is loaded into the output register. No new item is
// taken until this read-then-update step is complete; out_valid rises at the
// clock edge that ends the update step.
// An item may be accepted while the previous result still waits in the output
// register; if the receiver stalls, the update step holds until the register
// frees up, and no further item is taken meanwhile.
// Reset clears the sequencer (not running, LED on, all relays off) and loads
// the configuration defaults; the script table holds no defined contents
// until rows are loaded.
module timed_relay_show_sequencer_unit #(
    parameter int MAX_ROWS = trss_pkg::MAX_ROWS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  action,
    input  wire logic [trss_pkg::PRESS_W-1:0] press_ms,
    input  wire logic [7:0]                  row_slot,
    input  wire logic [trss_pkg::WAIT_W-1:0] row_wait_secs,
    input  wire logic [7:0]                  row_relay_bits,

    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       relay_pins,
    output logic                             led,
    output logic                             running,
    output logic                             paused,
    output logic [trss_pkg::ROW_W-1:0]       row_now,
    output logic                             finished,

    input  wire logic                        cfg_wr_en,
    input  wire logic [1:0]                  cfg_addr,
    input  wire logic [trss_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DATA_W = trss_pkg::WAIT_W + trss_pkg::RELAY_W;
    localparam logic [trss_pkg::CNT_W-1:0] ROWS_MAX = trss_pkg::CNT_W'(MAX_ROWS);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [trss_pkg::ROW_W-1:0]   row_count_reg;
    logic [trss_pkg::TPS_W-1:0]   ticks_sec_reg;
    logic [trss_pkg::BLINK_W-1:0] blink_half_reg;
    logic [trss_pkg::PRESS_W-1:0] long_press_reg;

    // Sequencer state.
    logic                           started_reg, started_next;
    logic                           playing_reg, playing_next;
    logic                           seq_reg, seq_next;
    logic                           load_pend_reg, load_pend_next;
    logic [trss_pkg::ROW_W-1:0]     row_ptr_reg, row_ptr_next;
    logic [trss_pkg::WAIT_W-1:0]    secs_left_reg, secs_left_next;
    logic [trss_pkg::TPS_W-1:0]     subsec_reg, subsec_next;
    logic [trss_pkg::BLINK_W-1:0]   blink_cnt_reg, blink_cnt_next;
    logic                           led_reg, led_next;
    logic [7:0]                     relays_reg, relays_next;

    // Item held between transfer and update.
    logic [1:0]                     act_reg;
    logic [trss_pkg::PRESS_W-1:0]   press_reg;
    logic                           rd_ok_reg;

    // Output register.
    logic                           out_valid_reg, out_valid_next;
    trss_pkg::result_t              result_reg, result_next;

    logic                           in_xfer;
    logic                           commit;
    logic [DATA_W-1:0]              rd_data;
    logic [trss_pkg::WAIT_W-1:0]    rd_wait;
    logic [7:0]                     rd_relays;
    logic [trss_pkg::CNT_W-1:0]     slot_ext;
    logic [trss_pkg::CNT_W-1:0]     ptr_ext;
    logic [trss_pkg::CNT_W-1:0]     rows_eff;
    logic [trss_pkg::CNT_W-1:0]     ptr_inc_ext;
    logic                           ram_we;
    logic                           done;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // Script table: wait seconds in the upper bits, relay states below.
    assign slot_ext = trss_pkg::CNT_W'(row_slot);
    assign ptr_ext  = trss_pkg::CNT_W'(row_ptr_reg);
    assign ram_we   = in_xfer && (action == trss_pkg::ACT_LOAD) && (slot_ext < ROWS_MAX);

    trss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata ({row_wait_secs, row_relay_bits}),
        .re    (in_xfer),
        .raddr (ptr_ext[AW-1:0]),
        .rdata (rd_data)
    );

    assign rd_wait   = rd_ok_reg ? rd_data[DATA_W-1:trss_pkg::RELAY_W] : '0;
    assign rd_relays = rd_ok_reg ? rd_data[trss_pkg::RELAY_W-1:0] : '0;

    // Rows in use, clamped to the table depth; zero counts as one.
    always_comb
    begin
        rows_eff = trss_pkg::CNT_W'(row_count_reg);
        if (rows_eff == '0)
        begin
            rows_eff = trss_pkg::CNT_W'(1);
        end
        if (rows_eff > ROWS_MAX)
        begin
            rows_eff = ROWS_MAX;
        end
    end

    assign ptr_inc_ext = ptr_ext + trss_pkg::CNT_W'(1);

    // Next-state logic for one item.
    always_comb
    begin
        started_next   = started_reg;
        playing_next   = playing_reg;
        seq_next       = seq_reg;
        load_pend_next = load_pend_reg;
        row_ptr_next   = row_ptr_reg;
        secs_left_next = secs_left_reg;
        subsec_next    = subsec_reg;
        blink_cnt_next = blink_cnt_reg;
        led_next       = led_reg;
        relays_next    = relays_reg;
        done           = 1'b0;

        case (act_reg)
            trss_pkg::ACT_TICK:
            begin
                // Blink the LED while paused.
                if (started_reg && !playing_reg)
                begin
                    blink_cnt_next = blink_cnt_reg + trss_pkg::BLINK_W'(1);
                    if (blink_cnt_next >= blink_half_reg)
                    begin
                        led_next       = !led_reg;
                        blink_cnt_next = '0;
                    end
                end
                if (seq_reg)
                begin
                    if (load_pend_reg)
                    begin
                        // Start the wait for the current row.
                        led_next       = 1'b0;
                        secs_left_next = rd_wait;
                        subsec_next    = '0;
                        load_pend_next = 1'b0;
                    end
                    else if (secs_left_reg == '0)
                    begin
                        // Wait ran out: apply the row and advance.
                        relays_next  = rd_relays & trss_pkg::RELAY_MASK;
                        row_ptr_next = ptr_inc_ext[trss_pkg::ROW_W-1:0];
                        if (ptr_inc_ext >= rows_eff)
                        begin
                            seq_next     = 1'b0;
                            started_next = 1'b0;
                            led_next     = 1'b1;
                            done         = 1'b1;
                        end
                        else
                        begin
                            load_pend_next = 1'b1;
                        end
                    end
                    else if (playing_reg)
                    begin
                        subsec_next = subsec_reg + trss_pkg::TPS_W'(1);
                        if (subsec_next >= ticks_sec_reg)
                        begin
                            subsec_next    = '0;
                            secs_left_next = secs_left_reg - trss_pkg::WAIT_W'(1);
                        end
                    end
                end
            end
            trss_pkg::ACT_BUTTON:
            begin
                if (press_reg != '0)
                begin
                    if (press_reg > long_press_reg)
                    begin
                        // Long press: stop and switch all relays off.
                        started_next = 1'b0;
                        seq_next     = 1'b0;
                        playing_next = 1'b0;
                        led_next     = 1'b1;
                        relays_next  = '0;
                    end
                    else if (!started_reg)
                    begin
                        // Short press while stopped: start from row 0.
                        seq_next       = 1'b1;
                        row_ptr_next   = '0;
                        load_pend_next = 1'b1;
                        led_next       = 1'b0;
                        relays_next    = '0;
                        playing_next   = 1'b1;
                        subsec_next    = '0;
                        started_next   = 1'b1;
                    end
                    else
                    begin
                        // Short press while started: toggle pause.
                        playing_next = !playing_reg;
                        if (!playing_reg)
                        begin
                            led_next = 1'b0;
                        end
                        else
                        begin
                            led_next       = 1'b1;
                            blink_cnt_next = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        result_next.relay_pins = (~relays_next) & trss_pkg::RELAY_MASK;
        result_next.led        = led_next;
        result_next.running    = seq_next;
        result_next.paused     = started_next && !playing_next;
        result_next.row_now    = row_ptr_next;
        result_next.finished   = done;
    end

    // Output register and handshake sequencing.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, configuration and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            row_count_reg  <= trss_pkg::ROW_COUNT_RST;
            ticks_sec_reg  <= trss_pkg::TICKS_SEC_RST;
            blink_half_reg <= trss_pkg::BLINK_HALF_RST;
            long_press_reg <= trss_pkg::LONG_PRESS_RST;
            started_reg    <= 1'b0;
            playing_reg    <= 1'b0;
            seq_reg        <= 1'b0;
            load_pend_reg  <= 1'b0;
            row_ptr_reg    <= '0;
            secs_left_reg  <= '0;
            subsec_reg     <= '0;
            blink_cnt_reg  <= '0;
            led_reg        <= 1'b1;
            relays_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    trss_pkg::CFG_ROW_COUNT:  row_count_reg  <= cfg_wdata[trss_pkg::ROW_W-1:0];
                    trss_pkg::CFG_TICKS_SEC:  ticks_sec_reg  <= cfg_wdata[trss_pkg::TPS_W-1:0];
                    trss_pkg::CFG_BLINK_HALF: blink_half_reg <= cfg_wdata[trss_pkg::BLINK_W-1:0];
                    trss_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_wdata[trss_pkg::PRESS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (commit)
            begin
                started_reg   <= started_next;
                playing_reg   <= playing_next;
                seq_reg       <= seq_next;
                load_pend_reg <= load_pend_next;
                row_ptr_reg   <= row_ptr_next;
                secs_left_reg <= secs_left_next;
                subsec_reg    <= subsec_next;
                blink_cnt_reg <= blink_cnt_next;
                led_reg       <= led_next;
                relays_reg    <= relays_next;
            end
        end
    end

    // Item payload and result payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg   <= action;
            press_reg <= press_ms;
            rd_ok_reg <= (ptr_ext < ROWS_MAX);
        end
        if (commit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign relay_pins = result_reg.relay_pins;
    assign led        = result_reg.led;
    assign running    = result_reg.running;
    assign paused     = result_reg.paused;
    assign row_now    = result_reg.row_now;
    assign finished   = result_reg.finished;

endmodule

`default_nettype wire

/* hdl/trss_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module trss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
